// ===== rtl/mtlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtlp_pkg
// Shared constants, types and lookup functions for the meter telegram line
// parser: identifier texts, parse phases, line kinds, result targets.
// ----------------------------------------------------------------------------
package mtlp_pkg;

  // Number format
  localparam int FRAC_DIGITS = 3;
  localparam int VALUE_W     = 32;
  localparam int OUT_W       = VALUE_W + 1;

  // Room for acc * 10 plus the largest digit weight
  localparam int ACC_EXT_W   = ((VALUE_W > 24) ? VALUE_W : 24) + 4;
  localparam int FCOUNT_W    = (FRAC_DIGITS < 1) ? 1 : $clog2(FRAC_DIGITS + 1);

  // Identifier matching
  localparam int N_PREFIX    = 8;
  localparam int GAS_IDX     = 6;
  localparam int POS_W       = 5;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Parse phases
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_PREFIX = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STAMP  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CLOSE  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_OPEN   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_INT    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_FRAC   = 3'd6;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd7;

  // Line kinds (1..4 energy registers, then power, gas)
  localparam int KIND_W = 4;
  localparam logic [KIND_W-1:0] KIND_NONE      = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LAST_REG  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_POWER_DEL = 4'd5;
  localparam logic [KIND_W-1:0] KIND_POWER_RET = 4'd6;

  // Result targets
  localparam int TARGET_W = 3;
  localparam logic [TARGET_W-1:0] TGT_POWER = 3'd4;
  localparam logic [TARGET_W-1:0] TGT_GAS   = 3'd5;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_S_UP  = 8'h53;
  localparam logic [7:0] CH_W_UP  = 8'h57;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  localparam logic [VALUE_W-1:0] VAL_MAX = '1;

  // Power of ten, used at elaboration and for small constant tables
  function automatic longint pow10(input int n);
    longint s;
    s = 1;
    for (int k = 0; k < n; k++) begin
      s = s * 10;
    end
    return s;
  endfunction

  localparam longint UNIT_SCALE = pow10(FRAC_DIGITS);

  // Weight of the fraction digit at position n (0 = tenths)
  function automatic logic [ACC_EXT_W-1:0] frac_scale(input logic [FCOUNT_W-1:0] n);
    logic [ACC_EXT_W-1:0] s;
    s = '0;
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      if (n == FCOUNT_W'(k)) begin
        s = ACC_EXT_W'(pow10(FRAC_DIGITS - 1 - k));
      end
    end
    return s;
  endfunction

  // Identifier length
  function automatic logic [POS_W-1:0] prefix_len(input int idx);
    logic [POS_W-1:0] len;
    case (idx)
      GAS_IDX: len = 5'd11;
      7:       len = 5'd1;
      default: len = 5'd10;
    endcase
    return len;
  endfunction

  // Identifier character at a position (space padded, gated by length)
  function automatic logic [7:0] prefix_char(input int idx, input logic [POS_W-1:0] pos);
    logic [87:0] txt;
    logic [3:0]  p;
    logic [7:0]  ch;
    case (idx)
      0:       txt = "1-0:1.8.1( ";
      1:       txt = "1-0:1.8.2( ";
      2:       txt = "1-0:2.8.1( ";
      3:       txt = "1-0:2.8.2( ";
      4:       txt = "1-0:1.7.0( ";
      5:       txt = "1-0:2.7.0( ";
      GAS_IDX: txt = "0-1:24.2.1(";
      default: txt = "(          ";
    endcase
    p  = pos[3:0];
    ch = CH_SPACE;
    if (pos < 5'd11) begin
      ch = txt[8*(10 - int'(p)) +: 8];
    end
    return ch;
  endfunction

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [N_PREFIX-1:0] cands;
    logic [PHASE_W-1:0]  phase;
    logic [VALUE_W-1:0]  acc;
    logic [FCOUNT_W-1:0] fcount;
    logic                digit_seen;
    logic [KIND_W-1:0]   kind;
  } state_t;

  typedef struct packed {
    logic                emit;
    logic [TARGET_W-1:0] target;
    logic [OUT_W-1:0]    value;
  } result_t;

  localparam state_t STATE_RESET = '{
    pos:        '0,
    cands:      '1,
    phase:      PH_PREFIX,
    acc:        '0,
    fcount:     '0,
    digit_seen: 1'b0,
    kind:       KIND_NONE
  };

endpackage

// ===== rtl/mtlp_if.sv =====
// ----------------------------------------------------------------------------
// mtlp_in_if / mtlp_out_if
// Valid/ready channels for line characters and decoded readings.
// ----------------------------------------------------------------------------
interface mtlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface mtlp_out_if;
  import mtlp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [TARGET_W-1:0]        target;
  logic signed [OUT_W-1:0]    value;

  modport source (output valid, output target, output value, input ready);
  modport sink   (input valid, input target, input value, output ready);
endinterface

// ===== rtl/mtlp_step.sv =====
// ----------------------------------------------------------------------------
// mtlp_step
// Per-character next-state logic: identifier match, gas timestamp, decimal
// accumulate with saturation, and the line-end decision.
// ----------------------------------------------------------------------------
module mtlp_step (
  input  mtlp_pkg::state_t  cur,
  input  logic [7:0]        char_code,
  input  logic              end_of_line,
  output mtlp_pkg::state_t  nxt,
  output mtlp_pkg::result_t res
);
  import mtlp_pkg::*;

  state_t               upd;
  logic                 is_digit;
  logic                 is_blank;
  logic                 is_exp;
  logic [3:0]           digit;
  logic [ACC_EXT_W-1:0] acc_ext;
  logic [ACC_EXT_W-1:0] int_add;
  logic [ACC_EXT_W-1:0] int_sum;
  logic [ACC_EXT_W-1:0] frac_add;
  logic [ACC_EXT_W-1:0] frac_sum;
  logic [POS_W:0]       pos_inc;
  logic [VALUE_W-1:0]   int_acc;
  logic [VALUE_W-1:0]   frac_acc;

  // Classify the character
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_blank = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign is_exp   = (char_code == CH_E_UP) || (char_code == CH_E_LO);
  assign digit    = 4'(char_code - CH_ZERO);
  assign pos_inc  = {1'b0, cur.pos} + 1'b1;

  // Integer digit: acc * 10 + d * unit, saturated
  assign acc_ext = ACC_EXT_W'(cur.acc);
  assign int_add = ACC_EXT_W'(digit) * ACC_EXT_W'(UNIT_SCALE);
  assign int_sum = (acc_ext << 3) + (acc_ext << 1) + int_add;
  assign int_acc = (int_sum > ACC_EXT_W'(VAL_MAX)) ? VAL_MAX : int_sum[VALUE_W-1:0];

  // Fraction digit: acc + d * weight, saturated
  assign frac_add = ACC_EXT_W'(digit) * frac_scale(cur.fcount);
  assign frac_sum = acc_ext + frac_add;
  assign frac_acc = (frac_sum > ACC_EXT_W'(VAL_MAX)) ? VAL_MAX : frac_sum[VALUE_W-1:0];

  // Advance the parse by one character
  always_comb begin
    upd = cur;
    case (cur.phase)
      PH_PREFIX: begin
        for (int i = 0; i < N_PREFIX; i++) begin
          if (cur.cands[i]) begin
            if ((cur.pos >= prefix_len(i)) || (prefix_char(i, cur.pos) != char_code)) begin
              upd.cands[i] = 1'b0;
            end else if (pos_inc == {1'b0, prefix_len(i)}) begin
              upd.kind  = KIND_W'(i + 1);
              upd.phase = (i == GAS_IDX) ? PH_STAMP : PH_SKIP;
            end
          end
        end
        if (cur.pos != POS_MAX) begin
          upd.pos = pos_inc[POS_W-1:0];
        end
        // Drop the line once no identifier can still match
        if ((upd.phase == PH_PREFIX) && (upd.cands == '0)) begin
          upd.kind  = KIND_NONE;
          upd.phase = PH_DONE;
        end
      end
      PH_STAMP: begin
        if (is_digit) begin
          upd.digit_seen = 1'b1;
        end else if (((char_code == CH_S_UP) || (char_code == CH_W_UP)) && cur.digit_seen) begin
          upd.digit_seen = 1'b0;
          upd.phase      = PH_CLOSE;
        end else begin
          upd.kind  = KIND_NONE;
          upd.phase = PH_DONE;
        end
      end
      PH_CLOSE: begin
        if (char_code == CH_RPAR) begin
          upd.phase = PH_OPEN;
        end else begin
          upd.kind  = KIND_NONE;
          upd.phase = PH_DONE;
        end
      end
      PH_OPEN: begin
        if (char_code == CH_LPAR) begin
          upd.phase = PH_SKIP;
        end else begin
          upd.kind  = KIND_NONE;
          upd.phase = PH_DONE;
        end
      end
      PH_SKIP, PH_INT, PH_FRAC: begin
        if ((cur.phase == PH_SKIP) && is_blank) begin
          upd = cur;
        end else if (is_digit && (cur.phase != PH_FRAC)) begin
          upd.digit_seen = 1'b1;
          upd.acc        = int_acc;
          upd.phase      = PH_INT;
        end else if (is_digit) begin
          upd.digit_seen = 1'b1;
          // Truncate digits beyond the kept fraction
          if (cur.fcount < FCOUNT_W'(FRAC_DIGITS)) begin
            upd.acc    = frac_acc;
            upd.fcount = cur.fcount + 1'b1;
          end
        end else if ((char_code == CH_DOT) && (cur.phase != PH_FRAC)) begin
          upd.phase = PH_FRAC;
        end else begin
          // End of number; no digits or an exponent invalidates the line
          if (!cur.digit_seen || is_exp) begin
            upd.kind = KIND_NONE;
          end
          upd.phase = PH_DONE;
        end
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  // Decide at line end and restart
  always_comb begin
    res.emit   = 1'b0;
    res.target = TARGET_W'(upd.kind - 1'b1);
    res.value  = {1'b0, upd.acc};
    nxt        = upd;
    if (end_of_line) begin
      nxt = STATE_RESET;
      if ((upd.kind != KIND_NONE) && upd.digit_seen && (upd.phase >= PH_SKIP)) begin
        if (upd.kind <= KIND_LAST_REG) begin
          res.emit = 1'b1;
        end else if ((upd.kind == KIND_POWER_DEL) || (upd.kind == KIND_POWER_RET)) begin
          res.emit   = (upd.acc != '0);
          res.target = TGT_POWER;
          if (upd.kind == KIND_POWER_RET) begin
            res.value = OUT_W'(0) - {1'b0, upd.acc};
          end
        end else begin
          res.emit   = 1'b1;
          res.target = TGT_GAS;
        end
      end
    end
  end

endmodule

// ===== rtl/meter_telegram_line_parser.sv =====
// ----------------------------------------------------------------------------
// meter_telegram_line_parser
// Takes one byte of a smart-meter telegram line per item, end_of_line on the
// last byte, and yields at most one reading per line: energy registers
// (deliver/return, low/high tariff), present power (signed, zero dropped) or
// gas, in exact thousandths saturated at 2^32-1. One byte is accepted every
// clock cycle unless a result waits untaken; a result is offered once its line's
// last byte has passed the input register, the per-byte step and the result
// register. While a result waits, the block takes one more byte into its
// input register and then stalls until the result is taken.
// ----------------------------------------------------------------------------
module meter_telegram_line_parser (
  input logic      clk,
  input logic      rst_n,
  mtlp_in_if.sink  in_ch,
  mtlp_out_if.source out_ch
);
  import mtlp_pkg::*;

  logic                s1_valid_r;
  logic [7:0]          s1_char_r;
  logic                s1_eol_r;
  logic                s1_adv;
  state_t              state_r;
  state_t              state_nxt;
  result_t             res;
  logic                out_valid_r;
  logic [TARGET_W-1:0] out_target_r;
  logic [OUT_W-1:0]    out_value_r;

  // Advance the held item when the result slot is free or draining
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_code;
      s1_eol_r  <= in_ch.end_of_line;
    end
  end

  // Per-byte parse step
  mtlp_step u_step (
    .cur         (state_r),
    .char_code   (s1_char_r),
    .end_of_line (s1_eol_r),
    .nxt         (state_nxt),
    .res         (res)
  );

  // Line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res.emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_target_r <= res.target;
      out_value_r  <= res.value;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.target = out_target_r;
  assign out_ch.value  = out_value_r;

  // No line kind while still matching the identifier
  a_kind_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_PREFIX) |-> (state_r.kind == KIND_NONE))
    else $error("line kind set during identifier match");

  // Line state restarts after the last byte of a line
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_eol_r) |=>
      ((state_r.phase == PH_PREFIX) && (state_r.pos == '0) && (state_r.acc == '0)))
    else $error("line state not cleared at line end");

  // Present power of zero never leaves the block
  a_power_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_target_r == TGT_POWER)) |-> (out_value_r != '0))
    else $error("zero present power emitted");

  // Only present power may be negative
  a_sign_power_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_value_r[OUT_W-1]) |-> (out_target_r == TGT_POWER))
    else $error("negative value on a non-power target");

  // Fraction digit count stays within the kept digits
  a_fcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fcount <= FCOUNT_W'(FRAC_DIGITS))
    else $error("fraction digit count overrun");

endmodule

// ===== tb/mtlp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtlp_checker
// Watches both channels of the meter telegram line parser. It runs its own
// byte-by-byte line decoder on every accepted character, queues the reading
// each finished line should give, and compares the readings that come out,
// in order, field by field.
// ----------------------------------------------------------------------------
module mtlp_checker (
  input  logic        clk,
  input  logic        rst_n,
  mtlp_in_if          in_ch,
  mtlp_out_if         out_ch,
  output int unsigned mismatch_count,
  output int unsigned readings_pending
);
  import mtlp_pkg::*;

  // Line kinds past the power lines
  localparam logic [KIND_W-1:0] KIND_GAS      = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FALLBACK = 4'd8;

  localparam int              ID_COUNT = 8;
  localparam longint unsigned MAG_MAX  = (64'd1 << VALUE_W) - 64'd1;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [OUT_W-1:0]    value;
  } reading_t;

  // Decoder state for the line in progress
  logic [POS_W-1:0]    line_pos;
  logic [ID_COUNT-1:0] id_hits;
  logic [PHASE_W-1:0]  phase;
  longint unsigned     magnitude;
  int unsigned         frac_count;
  bit                  saw_digit;
  logic [KIND_W-1:0]   line_kind;

  reading_t expected_readings[$];

  // Opening texts, in line-kind order (kind = index + 1)
  function automatic string id_text(input int idx);
    string s;
    case (idx)
      0:       s = "1-0:1.8.1(";
      1:       s = "1-0:1.8.2(";
      2:       s = "1-0:2.8.1(";
      3:       s = "1-0:2.8.2(";
      4:       s = "1-0:1.7.0(";
      5:       s = "1-0:2.7.0(";
      GAS_IDX: s = "0-1:24.2.1(";
      default: s = "(";
    endcase
    return s;
  endfunction

  function automatic void clear_line();
    line_pos   = '0;
    id_hits    = '1;
    phase      = PH_PREFIX;
    magnitude  = 0;
    frac_count = 0;
    saw_digit  = 1'b0;
    line_kind  = KIND_NONE;
  endfunction

  function automatic void reject_line();
    line_kind = KIND_NONE;
    phase     = PH_DONE;
  endfunction

  // A number with no digit, or one cut off by an exponent, is void
  function automatic void close_number(input logic [7:0] c);
    if (!saw_digit || c == CH_E_UP || c == CH_E_LO) begin
      line_kind = KIND_NONE;
    end
    phase = PH_DONE;
  endfunction

  function automatic void add_capped(input longint unsigned add);
    if (magnitude > MAG_MAX - add) begin
      magnitude = MAG_MAX;
    end else begin
      magnitude = magnitude + add;
    end
  endfunction

  function automatic void push_int_digit(input longint unsigned d);
    longint unsigned add;
    add       = d * UNIT_SCALE;
    saw_digit = 1'b1;
    if (add > MAG_MAX || magnitude > (MAG_MAX - add) / 10) begin
      magnitude = MAG_MAX;
    end else begin
      magnitude = magnitude * 10 + add;
    end
  endfunction

  // Digits past the kept fraction width are dropped
  function automatic void push_frac_digit(input longint unsigned d);
    longint unsigned weight;
    saw_digit = 1'b1;
    if (frac_count < FRAC_DIGITS) begin
      weight = UNIT_SCALE;
      for (int k = 0; k <= int'(frac_count); k++) begin
        weight = weight / 10;
      end
      add_capped(d * weight);
      frac_count++;
    end
  endfunction

  // Narrow the identifier candidates by one character
  function automatic void match_id(input logic [7:0] c);
    string txt;
    for (int i = 0; i < ID_COUNT; i++) begin
      txt = id_text(i);
      if (id_hits[i]) begin
        if (line_pos >= txt.len() || txt[line_pos] != c) begin
          id_hits[i] = 1'b0;
        end else if (line_pos + 1 == txt.len()) begin
          line_kind = KIND_W'(i + 1);
          phase     = (i == GAS_IDX) ? PH_STAMP : PH_SKIP;
        end
      end
    end
    if (line_pos != POS_MAX) begin
      line_pos++;
    end
    if (phase == PH_PREFIX && id_hits == '0) begin
      reject_line();
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    bit              is_digit;
    longint unsigned d;
    is_digit = (c >= CH_ZERO && c <= CH_NINE);
    d        = {56'd0, c - CH_ZERO};
    case (phase)
      PH_PREFIX: match_id(c);
      PH_STAMP: begin
        if (is_digit) begin
          saw_digit = 1'b1;
        end else if ((c == CH_S_UP || c == CH_W_UP) && saw_digit) begin
          saw_digit = 1'b0;
          phase     = PH_CLOSE;
        end else begin
          reject_line();
        end
      end
      PH_CLOSE: begin
        if (c == CH_RPAR) phase = PH_OPEN;
        else reject_line();
      end
      PH_OPEN: begin
        if (c == CH_LPAR) phase = PH_SKIP;
        else reject_line();
      end
      PH_SKIP: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          // skip leading blanks
        end else if (is_digit) begin
          push_int_digit(d);
          phase = PH_INT;
        end else if (c == CH_DOT) begin
          phase = PH_FRAC;
        end else begin
          close_number(c);
        end
      end
      PH_INT: begin
        if (is_digit) push_int_digit(d);
        else if (c == CH_DOT) phase = PH_FRAC;
        else close_number(c);
      end
      PH_FRAC: begin
        if (is_digit) push_frac_digit(d);
        else close_number(c);
      end
      default: ;
    endcase
  endfunction

  // Reading owed by the finished line, if any
  function automatic bit decide_line(output reading_t r);
    bit got;
    got = 1'b0;
    r   = '0;
    if (line_kind != KIND_NONE && saw_digit && phase >= PH_SKIP) begin
      if (line_kind <= KIND_LAST_REG) begin
        r.target = TARGET_W'(line_kind - 4'd1);
        r.value  = OUT_W'(magnitude);
        got      = 1'b1;
      end else if (line_kind == KIND_POWER_DEL || line_kind == KIND_POWER_RET) begin
        if (magnitude != 0) begin
          r.target = TGT_POWER;
          r.value  = (line_kind == KIND_POWER_RET) ? -OUT_W'(magnitude) : OUT_W'(magnitude);
          got      = 1'b1;
        end
      end else if (line_kind == KIND_GAS || line_kind == KIND_FALLBACK) begin
        r.target = TGT_GAS;
        r.value  = OUT_W'(magnitude);
        got      = 1'b1;
      end
    end
    return got;
  endfunction

  // Compare readings leaving, then decode the character entering
  always @(posedge clk) begin : watch
    reading_t    want;
    reading_t    made;
    int unsigned errs;
    errs = 0;
    if (!rst_n) begin
      clear_line();
      expected_readings.delete();
      mismatch_count   <= 0;
      readings_pending <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected reading: target %0d value %0d",
                 out_ch.target, $signed(out_ch.value));
          errs++;
        end else begin
          want = expected_readings.pop_front();
          if (out_ch.target !== want.target) begin
            $error("target mismatch: expected %0d, actual %0d", want.target, out_ch.target);
            errs++;
          end
          if (out_ch.value !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(want.value), $signed(out_ch.value));
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.char_code);
        if (in_ch.end_of_line) begin
          if (decide_line(made)) begin
            expected_readings.push_back(made);
          end
          clear_line();
        end
      end
      mismatch_count   <= mismatch_count + errs;
      readings_pending <= expected_readings.size();
    end
  end

endmodule

// ===== tb/tb_meter_telegram_line_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_meter_telegram_line_parser
// Feeds telegram lines to the parser one character per item: a directed set
// of lines covering every identifier and the odd number forms, then random
// well-formed, damaged and noise lines. The sender idles in bursts and the
// reader stalls on its own pattern, with long hold-offs that back the block
// up. Checking is done by mtlp_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_meter_telegram_line_parser;
  import mtlp_pkg::*;

  localparam int RANDOM_BYTES    = 1300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum int {RX_OPEN, RX_MASK, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;

  mtlp_in_if  in_ch ();
  mtlp_out_if out_ch ();

  int unsigned     mismatch_count;
  int unsigned     readings_pending;
  int unsigned     holds_asked;
  int unsigned     holds_done;
  int unsigned     cycle_count;
  logic [7:0]      line_buf[$];
  int unsigned     burst_left;
  bit              steady_send;
  int unsigned     random_bytes_sent;

  meter_telegram_line_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mtlp_checker reading_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .mismatch_count   (mismatch_count),
    .readings_pending (readings_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("meter_telegram_line_parser verification failed");
    $finish;
  end

  // Reader: stall patterns that change every stretch, plus long hold-offs
  initial begin : reader
    rx_mode_t    mode;
    logic [15:0] stall_mask;
    int unsigned run_len;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      mode       = rx_mode_t'($urandom_range(0, 3));
      stall_mask = 16'($urandom);
      run_len    = $urandom_range(20, 120);
      for (int k = 0; k < run_len; k++) begin
        @(negedge clk);
        if (holds_done < holds_asked) begin
          out_ch.ready = 1'b0;
          repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
          holds_done++;
        end
        case (mode)
          RX_OPEN:   out_ch.ready = 1'b1;
          RX_MASK:   out_ch.ready = stall_mask[k % 16];
          RX_MOSTLY: out_ch.ready = ($urandom_range(0, 3) != 0);
          default:   out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic string line_id(input int idx);
    string s;
    case (idx)
      0:       s = "1-0:1.8.1(";
      1:       s = "1-0:1.8.2(";
      2:       s = "1-0:2.8.1(";
      3:       s = "1-0:2.8.2(";
      4:       s = "1-0:1.7.0(";
      5:       s = "1-0:2.7.0(";
      GAS_IDX: s = "0-1:24.2.1(";
      default: s = "(";
    endcase
    return s;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_buf.push_back(s[i]);
    end
  endfunction

  function automatic void add_digits(input int n, input bit zeros);
    for (int i = 0; i < n; i++) begin
      line_buf.push_back(zeros ? CH_ZERO : 8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(CH_TAB, CH_CR)) : CH_SPACE;
  endfunction

  // Identifier, gas stamp, blanks, number and a random tail
  function automatic void build_good_line();
    int idx;
    int int_len;
    int frac_len;
    bit zero_value;
    line_buf.delete();
    idx = $urandom_range(0, 7);
    add_text(line_id(idx));
    if (idx == GAS_IDX) begin
      add_digits($urandom_range(1, 13), 1'b0);
      line_buf.push_back($urandom_range(0, 1) ? CH_S_UP : CH_W_UP);
      add_text(")(");
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(pick_blank());
    end
    int_len    = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
    frac_len   = $urandom_range(0, 6);
    zero_value = ($urandom_range(0, 5) == 0);
    if (int_len == 0 && frac_len == 0) int_len = 1;
    add_digits(int_len, zero_value);
    if (frac_len > 0 || $urandom_range(0, 3) == 0) line_buf.push_back(CH_DOT);
    add_digits(frac_len, zero_value);
    case ($urandom_range(0, 5))
      0: ;
      1: add_text("*kWh)");
      2: add_text("*m3)");
      3: add_text(")");
      4: line_buf.push_back(8'($urandom_range(0, 255)));
      default: begin
        line_buf.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
        add_digits($urandom_range(1, 2), 1'b0);
      end
    endcase
  endfunction

  // Well-formed line with one byte hit or the end cut off
  function automatic void build_broken_line();
    int cut;
    build_good_line();
    if ($urandom_range(0, 1) == 0) begin
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      cut = $urandom_range(1, line_buf.size());
      while (line_buf.size() > cut) void'(line_buf.pop_back());
    end
  endfunction

  function automatic void build_noise_line();
    line_buf.delete();
    repeat ($urandom_range(1, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Offer one character; return once it is taken
  task automatic send_byte(input logic [7:0] c, input bit eol);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (!steady_send) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.char_code   = c;
    in_ch.end_of_line = eol;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_byte(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    add_text(s);
    send_line();
  endtask

  initial begin : stimulus
    int pick;
    in_ch.valid       = 1'b0;
    in_ch.char_code   = 8'h00;
    in_ch.end_of_line = 1'b0;
    rst_n             = 1'b0;
    holds_asked       = 0;
    holds_done        = 0;
    burst_left        = 0;
    steady_send       = 1'b0;
    random_bytes_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed lines: each identifier, value extremes, odd number forms
    send_text("1-0:1.8.1(000123.456*kWh)");
    send_text("1-0:1.8.2(4294967.295*kWh)");
    send_text("1-0:1.8.2(4294967.2959)");
    send_text("1-0:2.8.1(99999999999*kWh)");
    send_text("1-0:2.8.2( \t\r12.3456789*kWh)");
    send_text("1-0:1.7.0(01.193*kW)");
    send_text("1-0:2.7.0(00.250*kW)");
    send_text("1-0:2.7.0(00.000*kW)");
    send_text("0-1:24.2.1(101209112500W)(12785.123*m3)");
    send_text("0-1:24.2.1(1S)(.5");
    send_text("(00123.45)");
    send_text("1-0:1.8.1(-5)");
    send_text("1-0:1.8.1(+5)");
    send_text("1-0:1.8.1(1.5e3)");
    send_text("(2E5)");
    send_text("1-0:1.8.1(inf)");
    send_text("(nan)");
    send_text("1-0:1.8.1(");
    send_text("1-0:1.8.1(.)");
    send_text("0-1:24.2.1(S)(1)");
    send_text("0-1:24.2.1(12 W)(1)");
    send_text("1-0:9.9.9(5)");
    send_text("1-0:1.8.1(7.");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    // Random lines, mostly well-formed; two long reader hold-offs on the way
    holds_asked = 1;
    while (random_bytes_sent < RANDOM_BYTES) begin
      if (random_bytes_sent > RANDOM_BYTES / 2 && holds_asked == 1) holds_asked = 2;
      if ($urandom_range(0, 7) == 0) steady_send = !steady_send;
      pick = $urandom_range(0, 9);
      if (pick < 7) build_good_line();
      else if (pick < 9) build_broken_line();
      else build_noise_line();
      send_line();
      random_bytes_sent += line_buf.size();
    end

    // Drain and give the verdict
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (readings_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && readings_pending == 0) begin
      $display("meter_telegram_line_parser verification clean");
    end else begin
      $display("meter_telegram_line_parser verification failed");
    end
    $finish;
  end

endmodule
